/* sv/lphm_pkg.sv */
// ----------------------------------------------------------------------------
// lphm_pkg
// Shared constants and types for the linear probing hash multimap.
// ----------------------------------------------------------------------------
package lphm_pkg;

  localparam int SLOTS_DEF        = 256;
  localparam int POOL_ENTRIES_DEF = 64;

  localparam logic [31:0] KEY_EMPTY = 32'hFFFF_FFFF;
  localparam logic [31:0] HASH_MULT = 32'd37;

  typedef enum logic [2:0] {
    ST_NEW        = 3'd0,
    ST_APPENDED   = 3'd1,
    ST_FOUND      = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_TABLE_FULL = 3'd4,
    ST_POOL_FULL  = 3'd5,
    ST_RESERVED   = 3'd6
  } status_t;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

endpackage

/* sv/lphm_hash.sv */
// ----------------------------------------------------------------------------
// lphm_hash
// Registered home slot: (key * 37) reduced to the slot count.
// ----------------------------------------------------------------------------
module lphm_hash #(
  parameter int SLOTS = lphm_pkg::SLOTS_DEF,
  localparam int SW = $clog2(SLOTS)
) (
  input  logic          clk,
  input  logic [31:0]   key,
  output logic [SW-1:0] home_r
);

  logic [31:0] prod;
  logic [SW-1:0] home_nxt;

  assign prod = key * lphm_pkg::HASH_MULT;

  // Slot count must be a power of two (unchecked), so the reduction is a mask.
  always_comb begin
    home_nxt = prod[SW-1:0];
  end

  always_ff @(posedge clk) begin
    home_r <= home_nxt;
  end

endmodule

/* sv/linear_probe_hash_multimap.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_multimap
// Open-addressed multimap with linear probing and a bump-allocated value pool.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  in      | in_valid/ready, action,key,val | sink
//  out     | out_valid/ready, status,val,lst| source
//
// One transaction at a time. Steps: accept, hash (S_HASH, S_HEAD), per slot probed
// a read and a compare (S_RD, S_CMP; one slot-key memory port), then hand off a
// single result, or on lookup each value (S_WALK_RD, S_WALK) and then finish.
// Reset clears control only; a clearing pass then writes the empty key into
// every slot while in_ready stays low. SLOTS must be a power of two (unchecked).
// A stalled out_ready holds the sequencer in its emit or walk state.
// ----------------------------------------------------------------------------
module linear_probe_hash_multimap #(
  parameter int SLOTS        = lphm_pkg::SLOTS_DEF,
  parameter int POOL_ENTRIES = lphm_pkg::POOL_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_value_out,
  output logic        out_last
);

  localparam int SW = $clog2(SLOTS);
  localparam int PW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int CW = $clog2(POOL_ENTRIES + 1);
  localparam int FW = $clog2(SLOTS + 1);
  localparam int FILL_LIMIT = (3 * SLOTS) / 4;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_RD, S_CMP, S_HEAD, S_WALK_RD, S_WALK, S_EMIT, S_DONE
  } state_t;

  // memories
  logic [31:0]  slot_key   [SLOTS];
  logic [PW-1:0] slot_head [SLOTS];
  logic [31:0]  pool_value [POOL_ENTRIES];
  logic [CW-1:0] pool_next [POOL_ENTRIES];

  state_t        state_r;
  logic          act_r;
  logic [31:0]   key_r, val_r;
  logic [SW-1:0] pos_r;
  logic [FW-1:0] n_r;        // probes done, also clear counter
  logic [CW-1:0] pool_used_r;
  logic [FW-1:0] filled_r;
  logic [31:0]   kq_r;       // registered slot key read
  logic [PW-1:0] hq_r;       // registered head read
  logic [CW-1:0] idx_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]   vq_r;
  logic [CW-1:0] nq_r;
  logic [2:0]    res_status_r; // single-result status, held until handoff
  logic [2:0]    o_status_r;
  logic [31:0]   o_value_r;
  logic          o_last_r, o_valid_r;
  logic          o_load;     // output register takes a new result
  logic [SW-1:0] home;

  lphm_hash #(.SLOTS(SLOTS)) u_hash (.clk(clk), .key(key_r), .home_r(home));

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = o_valid_r;
  assign out_status    = o_status_r;
  assign out_value_out = o_value_r;
  assign out_last      = o_last_r;

  assign o_load = ((state_r == S_EMIT) || (state_r == S_WALK)) && (!o_valid_r || out_ready);

  // memory ports: one read per memory per cycle, registered
  always_ff @(posedge clk) begin
    kq_r <= slot_key[pos_r];
    hq_r <= slot_head[pos_r];
    vq_r <= pool_value[idx_r[PW-1:0]];
    nq_r <= pool_next[idx_r[PW-1:0]];
    if (state_r == S_CLEAR) begin
      slot_key[n_r[SW-1:0]] <= lphm_pkg::KEY_EMPTY;
    end
    if (state_r == S_CMP && act_r == lphm_pkg::ACT_INSERT
        && (kq_r == key_r || kq_r == lphm_pkg::KEY_EMPTY)
        && !(kq_r == lphm_pkg::KEY_EMPTY && 32'(filled_r) > 32'(FILL_LIMIT))
        && 32'(pool_used_r) < 32'(POOL_ENTRIES)) begin
      pool_value[pool_used_r[PW-1:0]] <= val_r;
      slot_head[pos_r] <= pool_used_r[PW-1:0];
      if (kq_r == key_r) begin
        pool_next[pool_used_r[PW-1:0]] <= CW'(hq_r);
      end else begin
        pool_next[pool_used_r[PW-1:0]] <= CW'(POOL_ENTRIES);
        slot_key[pos_r] <= key_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      n_r         <= '0;
      pool_used_r <= '0;
      filled_r    <= '0;
      o_valid_r   <= 1'b0;
    end else begin
      if (o_load) o_valid_r <= 1'b1;
      else if (out_ready) o_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          n_r <= n_r + 1'b1;
          if (n_r == FW'(SLOTS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            act_r <= in_action;
            key_r <= in_key;
            val_r <= in_value;
            cnt_r <= '0;
            n_r   <= '0;
            if (in_key == lphm_pkg::KEY_EMPTY) begin
              res_status_r <= lphm_pkg::ST_RESERVED;
              state_r      <= S_EMIT;
            end else begin
              state_r <= S_HASH;
            end
          end
        end
        S_HASH: state_r <= S_HEAD;   // hash register settles
        S_HEAD: begin
          pos_r   <= home;
          state_r <= S_RD;
        end
        S_RD: state_r <= S_CMP;      // memory read of pos_r
        S_CMP: begin
          if (kq_r == key_r || kq_r == lphm_pkg::KEY_EMPTY) begin
            if (act_r == lphm_pkg::ACT_INSERT) begin
              state_r <= S_EMIT;
              if (kq_r == lphm_pkg::KEY_EMPTY && 32'(filled_r) > 32'(FILL_LIMIT)) begin
                res_status_r <= lphm_pkg::ST_TABLE_FULL;
              end else if (32'(pool_used_r) >= 32'(POOL_ENTRIES)) begin
                res_status_r <= lphm_pkg::ST_POOL_FULL;
              end else begin
                pool_used_r <= pool_used_r + 1'b1;
                if (kq_r == key_r) begin
                  res_status_r <= lphm_pkg::ST_APPENDED;
                end else begin
                  res_status_r <= lphm_pkg::ST_NEW;
                  filled_r     <= filled_r + 1'b1;
                end
              end
            end else if (kq_r == key_r) begin
              idx_r   <= CW'(hq_r);
              state_r <= S_WALK_RD;
            end else begin
              res_status_r <= lphm_pkg::ST_NOT_FOUND;
              state_r      <= S_EMIT;
            end
          end else if (n_r == FW'(SLOTS - 1)) begin
            res_status_r <= (act_r == lphm_pkg::ACT_INSERT) ? lphm_pkg::ST_TABLE_FULL
                                                           : lphm_pkg::ST_NOT_FOUND;
            state_r      <= S_EMIT;
          end else begin
            n_r     <= n_r + 1'b1;
            pos_r   <= pos_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_WALK_RD: begin
          // idx_r check; read issued this cycle
          if (idx_r < pool_used_r && 32'(cnt_r) < 32'(POOL_ENTRIES)) begin
            state_r <= S_WALK;
          end else begin
            res_status_r <= lphm_pkg::ST_NOT_FOUND;
            state_r      <= S_EMIT;
          end
        end
        S_WALK: begin
          // present value once the output register is free
          if (o_load) begin
            o_status_r <= lphm_pkg::ST_FOUND;
            o_value_r  <= vq_r;
            o_last_r   <= !(nq_r < pool_used_r && 32'(cnt_r) + 1 < 32'(POOL_ENTRIES));
            cnt_r      <= cnt_r + 1'b1;
            idx_r      <= nq_r;
            if (nq_r < pool_used_r && 32'(cnt_r) + 1 < 32'(POOL_ENTRIES)) begin
              state_r <= S_WALK_RD;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_EMIT: begin
          if (o_load) begin
            o_status_r <= res_status_r;
            o_value_r  <= '0;
            o_last_r   <= 1'b1;
            state_r    <= S_IDLE;
          end
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for linear_probe_hash_multimap. A behavioral copy of the
// table and the value pool predicts every result of each accepted transaction.
// Directed cases come first, then random traffic mostly over a small set of keys,
// with sender and receiver stalls. Pool exhaustion and a long receiver stall
// are both exercised.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NSLOT = lphm_pkg::SLOTS_DEF;
  localparam int NPOOL = lphm_pkg::POOL_ENTRIES_DEF;
  localparam int FILL_MAX = (3 * NSLOT) / 4;

  typedef struct packed {
    lphm_pkg::status_t status;
    logic [31:0]       value;
    logic              last;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_action;
  logic [31:0] in_key;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [31:0] out_value_out;
  logic        out_last;

  linear_probe_hash_multimap i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_key        (in_key),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_value_out (out_value_out),
    .out_last      (out_last)
  );

  // 10 ns clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Shadow of the table contents
  logic [31:0] tbl_key  [NSLOT];
  logic [5:0]  tbl_head [NSLOT];
  logic [31:0] pool_val [NPOOL];
  logic [6:0]  pool_nxt [NPOOL];
  int          pool_cnt;
  int          fill_cnt;

  answer_t     answer_q[$];
  int          n_sent;
  int          n_checked;
  int          n_errors;
  int          n_pool_full;
  int          n_multi;

  // Stall knobs: idle chances in percent of cycles, and a receiver hold-off length
  int          src_idle;
  int          dst_idle;
  int          hold_cycles;

  // Key set for random traffic: a few collide on the same home slot
  logic [31:0] key_set[16];

  // Predict the results of one transaction and queue them
  function automatic void predict_table(logic act, logic [31:0] key, logic [31:0] val);
    logic [7:0] pos;
    int         hit;
    int         n;
    int         idx;
    int         cnt;
    answer_t    a;
    a.value = '0;
    a.last  = 1'b1;
    if (key == lphm_pkg::KEY_EMPTY) begin
      a.status = lphm_pkg::ST_RESERVED;
      answer_q.push_back(a);
      return;
    end
    // home slot is the low bits of key * 37
    pos = 8'(key * lphm_pkg::HASH_MULT);
    hit = -1;
    for (n = 0; n < NSLOT; n++) begin
      if (tbl_key[pos] == lphm_pkg::KEY_EMPTY) begin
        hit = 0;
        break;
      end
      if (tbl_key[pos] == key) begin
        hit = 1;
        break;
      end
      pos = pos + 8'd1;
    end
    if (act == lphm_pkg::ACT_INSERT) begin
      if (hit < 0 || (hit == 0 && fill_cnt > FILL_MAX)) begin
        a.status = lphm_pkg::ST_TABLE_FULL;
      end else if (pool_cnt >= NPOOL) begin
        a.status = lphm_pkg::ST_POOL_FULL;
        n_pool_full++;
      end else begin
        pool_val[pool_cnt] = val;
        if (hit == 1) begin
          pool_nxt[pool_cnt] = 7'(tbl_head[pos]);
          a.status = lphm_pkg::ST_APPENDED;
        end else begin
          pool_nxt[pool_cnt] = 7'(NPOOL);
          tbl_key[pos] = key;
          fill_cnt++;
          a.status = lphm_pkg::ST_NEW;
        end
        tbl_head[pos] = 6'(pool_cnt);
        pool_cnt++;
      end
      answer_q.push_back(a);
      return;
    end
    if (hit != 1) begin
      a.status = lphm_pkg::ST_NOT_FOUND;
      answer_q.push_back(a);
      return;
    end
    // list walk, newest first
    idx = tbl_head[pos];
    cnt = 0;
    a.status = lphm_pkg::ST_FOUND;
    a.last   = 1'b0;
    while (idx < pool_cnt && cnt < NPOOL) begin
      a.value = pool_val[idx];
      answer_q.push_back(a);
      cnt++;
      idx = pool_nxt[idx];
    end
    if (cnt == 0) begin
      a.status = lphm_pkg::ST_NOT_FOUND;
      a.value  = '0;
      a.last   = 1'b1;
      answer_q.push_back(a);
    end else begin
      answer_q[answer_q.size() - 1].last = 1'b1;
      if (cnt > 1) n_multi++;
    end
  endfunction

  // Offer one transaction; predict at the accepting edge
  task automatic send_item(logic act, logic [31:0] key, logic [31:0] val);
    while ($urandom_range(99) < src_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    in_action = act;
    in_key    = key;
    in_value  = val;
    do @(posedge clk); while (!in_ready);
    predict_table(act, key, val);
    n_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (answer_q.size() != 0) @(negedge clk);
  endtask

  // Receiver: random stalls, plus a counted long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready   = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready = ($urandom_range(99) >= dst_idle);
    end
  end

  // Result checker
  always @(posedge clk) begin
    answer_t exp_a;
    if (rst_n && out_valid && out_ready) begin
      n_checked++;
      if (answer_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR: unexpected result status=%0d value=%h last=%b",
                   out_status, out_value_out, out_last);
      end else begin
        exp_a = answer_q.pop_front();
        if (out_status !== exp_a.status || out_value_out !== exp_a.value ||
            out_last !== exp_a.last) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: result mismatch exp st=%0d val=%h last=%b got st=%0d val=%h last=%b",
                     exp_a.status, exp_a.value, exp_a.last,
                     out_status, out_value_out, out_last);
        end
      end
    end
  end

  // Corners: reserved key, empty lookups, extreme keys and values, appends
  task automatic test_directed();
    send_item(lphm_pkg::ACT_LOOKUP, lphm_pkg::KEY_EMPTY, 32'h0);
    send_item(lphm_pkg::ACT_INSERT, lphm_pkg::KEY_EMPTY, 32'h1234);
    send_item(lphm_pkg::ACT_LOOKUP, 32'h0, 32'hFFFF_FFFF);
    send_item(lphm_pkg::ACT_INSERT, 32'h0, 32'h0);
    send_item(lphm_pkg::ACT_INSERT, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_item(lphm_pkg::ACT_INSERT, 32'h0, 32'hFFFF_FFFF);
    send_item(lphm_pkg::ACT_INSERT, 32'h0, 32'hA5A5_5A5A);
    send_item(lphm_pkg::ACT_LOOKUP, 32'h0, 32'h0);
    send_item(lphm_pkg::ACT_LOOKUP, 32'hFFFF_FFFE, 32'h0);
    // same home slot as key 0, so it probes past it
    send_item(lphm_pkg::ACT_INSERT, 32'h0000_0100, 32'h5A5A_A5A5);
    send_item(lphm_pkg::ACT_LOOKUP, 32'h0000_0100, 32'h0);
    send_item(lphm_pkg::ACT_LOOKUP, 32'h0000_0200, 32'h0);
    send_item(lphm_pkg::ACT_INSERT, 32'h8000_0000, 32'h8000_0001);
    send_item(lphm_pkg::ACT_LOOKUP, 32'h8000_0000, 32'h0);
    send_item(lphm_pkg::ACT_LOOKUP, lphm_pkg::KEY_EMPTY, 32'hFFFF_FFFF);
  endtask

  // Mostly inserts and lookups over the key set, some random noise keys
  task automatic test_random(int n_items, int s_idle, int d_idle);
    int          i;
    int          r;
    logic        act;
    logic [31:0] key;
    src_idle = s_idle;
    dst_idle = d_idle;
    for (i = 0; i < n_items; i++) begin
      r   = $urandom_range(99);
      act = ($urandom_range(99) < 45) ? lphm_pkg::ACT_INSERT : lphm_pkg::ACT_LOOKUP;
      if (r < 80)      key = key_set[$urandom_range(15)];
      else if (r < 97) key = $urandom;
      else             key = lphm_pkg::KEY_EMPTY;
      send_item(act, key, $urandom);
    end
  endtask

  // Receiver holds off while lookups pile up behind the block
  task automatic test_backpressure();
    int i;
    src_idle    = 0;
    dst_idle    = 0;
    hold_cycles = 300;
    for (i = 0; i < 10; i++)
      send_item(lphm_pkg::ACT_LOOKUP, key_set[$urandom_range(3)], $urandom);
  endtask

  // Sender pauses until every pending result is out, then resumes
  task automatic test_drain_pause();
    wait_drained();
    send_item(lphm_pkg::ACT_LOOKUP, key_set[0], 32'h0);
    send_item(lphm_pkg::ACT_INSERT, key_set[1], $urandom);
  endtask

  initial begin
    int i;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_action   = lphm_pkg::ACT_INSERT;
    in_key      = '0;
    in_value    = '0;
    out_ready   = 1'b0;
    src_idle    = 0;
    dst_idle    = 0;
    hold_cycles = 0;
    n_sent      = 0;
    n_checked   = 0;
    n_errors    = 0;
    n_pool_full = 0;
    n_multi     = 0;
    pool_cnt    = 0;
    fill_cnt    = 0;
    for (i = 0; i < NSLOT; i++) begin
      tbl_key[i]  = lphm_pkg::KEY_EMPTY;
      tbl_head[i] = '0;
    end
    for (i = 0; i < NPOOL; i++) begin
      pool_val[i] = '0;
      pool_nxt[i] = 7'(NPOOL);
    end
    // four keys sharing one home slot, the rest random
    for (i = 0; i < 16; i++)
      key_set[i] = (i < 4) ? 32'h0000_0037 + 32'(i) * 32'h100 : $urandom;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(90, 32, 58);
    test_backpressure();
    test_drain_pause();
    test_random(90, 58, 32);
    test_random(70, 0, 0);

    wait_drained();
    repeat (50) @(posedge clk);
    $display("Covered %0d transactions, %0d results checked, %0d multi-value lookups,",
             n_sent, n_checked, n_multi);
    $display("%0d pool-full refusals, with long receiver hold-off and drained pause.",
             n_pool_full);
    if (n_errors == 0 && answer_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, answer_q.size());
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("timeout");
    $display("simulation failed");
    $finish;
  end

endmodule
